>>> rtl/ora_pkg.sv
// Shared widths, pipeline stage map and register indexes for the oriented
// rectangle bounds block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ora_pkg;

   typedef logic signed [31:0] q16_type;

   localparam int FRAC  = 16;          // fraction bits of Q16.16
   localparam int MW    = 22;          // rotation matrix entry, Q.16 signed
   localparam int MAGW  = 21;          // magnitude of a matrix entry
   localparam int SSQW  = 42;          // sum of squares of one column
   localparam int ROOTW = 21;          // column norm
   localparam int QW    = FRAC + 1;    // normalized axis component, up to 1.0
   localparam int CTRW  = 56;          // unsaturated center
   localparam int HW    = 47;          // rounded half extent after scaling
   localparam int EXTW  = 49;          // rounded per-axis extent

   localparam int SQ_PER = 3;          // root digits per stage
   localparam int DV_PER = 3;          // quotient bits per stage

   localparam int ST_FRONT = 4;
   localparam int ST_SQRT  = (ROOTW + SQ_PER - 1) / SQ_PER;
   localparam int ST_DIV   = (QW + DV_PER - 1) / DV_PER;
   localparam int ST_BACK  = 4;
   localparam int SQ_BASE  = ST_FRONT;
   localparam int DV_BASE  = SQ_BASE + ST_SQRT;
   localparam int BK_BASE  = DV_BASE + ST_DIV;
   localparam int ST_TOTAL = BK_BASE + ST_BACK;

   localparam int CSR_IDXW = 3;
   localparam logic [CSR_IDXW-1:0] CSR_OFFSET_X = 3'd0;
   localparam logic [CSR_IDXW-1:0] CSR_OFFSET_Y = 3'd1;
   localparam logic [CSR_IDXW-1:0] CSR_OFFSET_Z = 3'd2;
   localparam logic [CSR_IDXW-1:0] CSR_HALF_U   = 3'd3;
   localparam logic [CSR_IDXW-1:0] CSR_HALF_V   = 3'd4;

   localparam logic [9:0] EPS_Q16 = 10'd655;   // slab half thickness 0.01

endpackage

`default_nettype wire

>>> rtl/ora_front.sv
// Front stages: rotation matrix, center, column sums of squares and
// scaled half extents. Depends on ora_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ora_front (
   input  logic                        clock,
   input  logic [ora_pkg::ST_FRONT-1:0] stage_en,
   input  ora_pkg::q16_type            pos [3],
   input  ora_pkg::q16_type            scl [3],
   input  ora_pkg::q16_type            off [3],
   input  ora_pkg::q16_type            half_u,
   input  ora_pkg::q16_type            half_v,
   input  logic signed [15:0]          quat_w,
   input  logic signed [15:0]          quat_x,
   input  logic signed [15:0]          quat_y,
   input  logic signed [15:0]          quat_z,
   output logic signed [ora_pkg::CTRW-1:0] ctr [3],
   output logic [ora_pkg::HW-1:0]      hu,
   output logic [ora_pkg::HW-1:0]      hv,
   output logic [ora_pkg::SSQW-1:0]    sumsq [3],
   output logic [ora_pkg::MAGW-1:0]    mag [3][3]
);
   import ora_pkg::*;

   localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

   function automatic logic signed [MW-1:0] round_q16(input logic signed [34:0] v);
      logic signed [34:0] t;
      t = v + 35'sd2048;
      return t[MW+11:12];
   endfunction

   // Stage 1: quaternion products, matrix entries, offset and half size products.
   logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
   logic signed [34:0] mq [3][3];
   logic signed [63:0] prod_in [3];
   logic signed [63:0] hup_in, hvp_in;

   assign xx = quat_x * quat_x;
   assign yy = quat_y * quat_y;
   assign zz = quat_z * quat_z;
   assign xy = quat_x * quat_y;
   assign xz = quat_x * quat_z;
   assign yz = quat_y * quat_z;
   assign wx = quat_w * quat_x;
   assign wy = quat_w * quat_y;
   assign wz = quat_w * quat_z;

   always_comb begin
      mq[0][0] = ONE_Q28 - ((35'(yy) + 35'(zz)) <<< 1);
      mq[1][1] = ONE_Q28 - ((35'(xx) + 35'(zz)) <<< 1);
      mq[2][2] = ONE_Q28 - ((35'(xx) + 35'(yy)) <<< 1);
      mq[0][1] = (35'(xy) - 35'(wz)) <<< 1;
      mq[0][2] = (35'(xz) + 35'(wy)) <<< 1;
      mq[1][0] = (35'(xy) + 35'(wz)) <<< 1;
      mq[1][2] = (35'(yz) - 35'(wx)) <<< 1;
      mq[2][0] = (35'(xz) - 35'(wy)) <<< 1;
      mq[2][1] = (35'(yz) + 35'(wx)) <<< 1;
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = off[j] * scl[j];
      end
      hup_in = half_u * scl[0];
      hvp_in = half_v * scl[2];
   end

   logic signed [MW-1:0] m1_ff [3][3];
   logic signed [63:0]   s1_ff [3];
   logic signed [63:0]   hup1_ff, hvp1_ff;
   q16_type              pos1_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               m1_ff[i][j] <= round_q16(mq[i][j]);
            end
         end
         s1_ff   <= prod_in;
         hup1_ff <= hup_in;
         hvp1_ff <= hvp_in;
         pos1_ff <= pos;
      end
   end

   // Stage 2: split partial products of matrix times scaled offset, squares.
   logic [MAGW-1:0]        mag1 [3][3];
   logic signed [53:0]     ph_in [3][3];
   logic signed [54:0]     pl_in [3][3];
   logic [2*MAGW-2:0]      sq_in [3][3];
   logic [63:0]            hua_in, hva_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mag1[i][j]  = m1_ff[i][j][MW-1] ? MAGW'(-m1_ff[i][j]) : MAGW'(m1_ff[i][j]);
            ph_in[i][j] = m1_ff[i][j] * $signed(s1_ff[j][63:32]);
            pl_in[i][j] = m1_ff[i][j] * $signed({1'b0, s1_ff[j][31:0]});
            sq_in[i][j] = mag1[i][j] * mag1[i][j];
         end
      end
      hua_in = hup1_ff[63] ? 64'(-hup1_ff) : 64'(hup1_ff);
      hva_in = hvp1_ff[63] ? 64'(-hvp1_ff) : 64'(hvp1_ff);
   end

   logic signed [53:0] ph2_ff [3][3];
   logic signed [54:0] pl2_ff [3][3];
   logic [2*MAGW-2:0]  sq2_ff [3][3];
   logic [MAGW-1:0]    mag2_ff [3][3];
   logic [63:0]        hua2_ff, hva2_ff;
   q16_type            pos2_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         ph2_ff  <= ph_in;
         pl2_ff  <= pl_in;
         sq2_ff  <= sq_in;
         mag2_ff <= mag1;
         hua2_ff <= hua_in;
         hva2_ff <= hva_in;
         pos2_ff <= pos1_ff;
      end
   end

   // Stage 3: row sums, column sums of squares, half extent rounding.
   logic signed [CTRW-1:0] hs_in [3];
   logic signed [56:0]     ls_in [3];
   logic [SSQW-1:0]        ssq_in [3];
   logic [63:0]            hur_in, hvr_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hs_in[i]  = CTRW'(ph2_ff[i][0]) + CTRW'(ph2_ff[i][1]) + CTRW'(ph2_ff[i][2]);
         ls_in[i]  = 57'(pl2_ff[i][0]) + 57'(pl2_ff[i][1]) + 57'(pl2_ff[i][2]);
         ssq_in[i] = SSQW'(sq2_ff[0][i]) + SSQW'(sq2_ff[1][i]) + SSQW'(sq2_ff[2][i]);
      end
      hur_in = hua2_ff + 64'h8000;
      hvr_in = hva2_ff + 64'h8000;
   end

   logic signed [CTRW-1:0] hs3_ff [3];
   logic signed [56:0]     ls3_ff [3];
   logic [SSQW-1:0]        ssq3_ff [3];
   logic [HW-1:0]          hu3_ff, hv3_ff;
   logic [MAGW-1:0]        mag3_ff [3][3];
   q16_type                pos3_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         hs3_ff  <= hs_in;
         ls3_ff  <= ls_in;
         ssq3_ff <= ssq_in;
         hu3_ff  <= hur_in[HW+FRAC-1:FRAC];
         hv3_ff  <= hvr_in[HW+FRAC-1:FRAC];
         mag3_ff <= mag2_ff;
         pos3_ff <= pos2_ff;
      end
   end

   // Stage 4: center = position + high part + rounded low part.
   logic signed [57:0]     lr [3];
   logic signed [CTRW-1:0] ctr_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lr[i]     = 58'(ls3_ff[i]) + 58'sd2147483648;
         ctr_in[i] = CTRW'(pos3_ff[i]) + hs3_ff[i] + CTRW'($signed(lr[i][57:32]));
      end
   end

   logic signed [CTRW-1:0] ctr4_ff [3];
   logic [HW-1:0]          hu4_ff, hv4_ff;
   logic [SSQW-1:0]        ssq4_ff [3];
   logic [MAGW-1:0]        mag4_ff [3][3];

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         ctr4_ff <= ctr_in;
         hu4_ff  <= hu3_ff;
         hv4_ff  <= hv3_ff;
         ssq4_ff <= ssq3_ff;
         mag4_ff <= mag3_ff;
      end
   end

   assign ctr   = ctr4_ff;
   assign hu    = hu4_ff;
   assign hv    = hv4_ff;
   assign sumsq = ssq4_ff;
   assign mag   = mag4_ff;

endmodule

`default_nettype wire

>>> rtl/ora_sqrt.sv
// Pipelined integer square root of one column's sum of squares, a few
// digits per stage; carries the column magnitudes along. Depends on ora_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ora_sqrt (
   input  logic                        clock,
   input  logic [ora_pkg::ST_SQRT-1:0] stage_en,
   input  logic [ora_pkg::SSQW-1:0]    ssq,
   input  logic [ora_pkg::MAGW-1:0]    mag_in [3],
   output logic [ora_pkg::ROOTW-1:0]   root_out,
   output logic [ora_pkg::MAGW-1:0]    mag_out [3]
);
   import ora_pkg::*;

   localparam int REMW = ROOTW + 1;

   logic [SSQW-1:0]  rad_ff  [ST_SQRT];
   logic [REMW-1:0]  rem_ff  [ST_SQRT];
   logic [ROOTW-1:0] root_ff [ST_SQRT];
   logic [MAGW-1:0]  mag_ff  [ST_SQRT][3];

   for (genvar s = 0; s < ST_SQRT; s++) begin : g_stage
      logic [SSQW-1:0]  rad_src, rad_in;
      logic [REMW-1:0]  rem_src, rem_in;
      logic [ROOTW-1:0] root_src, root_in;
      logic [MAGW-1:0]  mag_src [3];

      if (s == 0) begin : g_head
         assign rad_src  = ssq;
         assign rem_src  = '0;
         assign root_src = '0;
         assign mag_src  = mag_in;
      end else begin : g_body
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign mag_src  = mag_ff[s-1];
      end

      // Restoring digit recurrence: two radicand bits in, one root bit out.
      always_comb begin
         logic [REMW+1:0] rw;
         logic [REMW+1:0] trial;
         rw      = '0;
         trial   = '0;
         rad_in  = rad_src;
         rem_in  = rem_src;
         root_in = root_src;
         for (int p = 0; p < SQ_PER; p++) begin
            if (s * SQ_PER + p < ROOTW) begin
               rw    = {rem_in, rad_in[SSQW-1 -: 2]};
               trial = {1'b0, root_in, 2'b01};
               if (rw >= trial) begin
                  rw      = rw - trial;
                  root_in = {root_in[ROOTW-2:0], 1'b1};
               end else begin
                  root_in = {root_in[ROOTW-2:0], 1'b0};
               end
               rem_in = rw[REMW-1:0];
               rad_in = rad_in << 2;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            mag_ff[s]  <= mag_src;
         end
      end
   end

   assign root_out = root_ff[ST_SQRT-1];
   assign mag_out  = mag_ff[ST_SQRT-1];

endmodule

`default_nettype wire

>>> rtl/ora_div.sv
// Pipelined rounded division round(a * 2^16 / n) for one axis component,
// a few quotient bits per stage; a zero norm gives zero. Depends on ora_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ora_div (
   input  logic                       clock,
   input  logic [ora_pkg::ST_DIV-1:0] stage_en,
   input  logic [ora_pkg::MAGW-1:0]   num_a,
   input  logic [ora_pkg::ROOTW-1:0]  den,
   output logic [ora_pkg::QW-1:0]     quo
);
   import ora_pkg::*;

   localparam int NW = ROOTW + QW;

   logic [ROOTW-1:0] rem_ff [ST_DIV];
   logic [QW-1:0]    low_ff [ST_DIV];
   logic [ROOTW-1:0] den_ff [ST_DIV];

   // The quotient never exceeds 1.0, so the top of the dividend starts
   // below the divisor and only the low bits need a step each.
   logic [NW-1:0] num;
   assign num = NW'({num_a, FRAC'(0)}) + NW'(den >> 1);

   for (genvar s = 0; s < ST_DIV; s++) begin : g_stage
      logic [ROOTW-1:0] rem_src, rem_in;
      logic [QW-1:0]    low_src, low_in;
      logic [ROOTW-1:0] den_src;

      if (s == 0) begin : g_head
         assign rem_src = num[NW-1:QW];
         assign low_src = num[QW-1:0];
         assign den_src = den;
      end else begin : g_body
         assign rem_src = rem_ff[s-1];
         assign low_src = low_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      always_comb begin
         logic [ROOTW:0] rw;
         logic           qb;
         rw     = '0;
         qb     = 1'b0;
         rem_in = rem_src;
         low_in = low_src;
         for (int p = 0; p < DV_PER; p++) begin
            if (s * DV_PER + p < QW) begin
               rw = {rem_in, low_in[QW-1]};
               qb = (rw >= {1'b0, den_src});
               if (qb) begin
                  rw = rw - {1'b0, den_src};
               end
               rem_in = rw[ROOTW-1:0];
               low_in = {low_in[QW-2:0], qb};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rem_ff[s] <= rem_in;
            low_ff[s] <= low_in;
            den_ff[s] <= den_src;
         end
      end
   end

   assign quo = (den_ff[ST_DIV-1] == '0) ? '0 : low_ff[ST_DIV-1];

endmodule

`default_nettype wire

>>> rtl/ora_back.sv
// Back stages: per-axis extent from the unit axes and half extents, bounds
// around the center, saturation and the output register. Depends on ora_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ora_back (
   input  logic                            clock,
   input  logic [ora_pkg::ST_BACK-1:0]     stage_en,
   input  logic signed [ora_pkg::CTRW-1:0] ctr [3],
   input  logic [ora_pkg::HW-1:0]          hu,
   input  logic [ora_pkg::HW-1:0]          hv,
   input  logic [ora_pkg::QW-1:0]          ua [3],
   input  logic [ora_pkg::QW-1:0]          va [3],
   input  logic [ora_pkg::QW-1:0]          na [3],
   output ora_pkg::q16_type                min_out [3],
   output ora_pkg::q16_type                max_out [3],
   output logic                            sat_out
);
   import ora_pkg::*;

   localparam int EW  = 65;
   localparam int BW  = CTRW + 2;
   localparam int HHW = HW - 32;
   localparam logic signed [BW-1:0] Q_MAX = BW'(64'sh7FFF_FFFF);
   localparam logic signed [BW-1:0] Q_MIN = BW'(-64'sh8000_0000);

   // Returns {clipped, value}.
   function automatic logic [32:0] sat32(input logic signed [BW-1:0] v);
      logic [32:0] r;
      if (v > Q_MAX) begin
         r = {1'b1, Q_MAX[31:0]};
      end else if (v < Q_MIN) begin
         r = {1'b1, Q_MIN[31:0]};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // Stage 1: half extents split at bit 32 to keep multipliers narrow.
   logic [QW+31:0]     pul_in [3], pvl_in [3];
   logic [QW+HHW-1:0]  puh_in [3], pvh_in [3];
   logic [QW+9:0]      pn_in  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pul_in[i] = ua[i] * hu[31:0];
         puh_in[i] = ua[i] * hu[HW-1:32];
         pvl_in[i] = va[i] * hv[31:0];
         pvh_in[i] = va[i] * hv[HW-1:32];
         pn_in[i]  = na[i] * EPS_Q16;
      end
   end

   logic [QW+31:0]         pul1_ff [3], pvl1_ff [3];
   logic [QW+HHW-1:0]      puh1_ff [3], pvh1_ff [3];
   logic [QW+9:0]          pn1_ff  [3];
   logic signed [CTRW-1:0] ctr1_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pul1_ff <= pul_in;
         puh1_ff <= puh_in;
         pvl1_ff <= pvl_in;
         pvh1_ff <= pvh_in;
         pn1_ff  <= pn_in;
         ctr1_ff <= ctr;
      end
   end

   // Stage 2: exact extent sum in Q.32.
   logic [EW-1:0] e_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_in[i] = EW'(pul1_ff[i]) + (EW'(puh1_ff[i]) << 32)
                 + EW'(pvl1_ff[i]) + (EW'(pvh1_ff[i]) << 32) + EW'(pn1_ff[i]);
      end
   end

   logic [EW-1:0]          e2_ff   [3];
   logic signed [CTRW-1:0] ctr2_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         e2_ff   <= e_in;
         ctr2_ff <= ctr1_ff;
      end
   end

   // Stage 3: round the extent to Q.16.
   logic [EW-1:0] er [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         er[i] = e2_ff[i] + EW'(32'h8000);
      end
   end

   logic [EXTW-1:0]        ext3_ff [3];
   logic signed [CTRW-1:0] ctr3_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int i = 0; i < 3; i++) begin
            ext3_ff[i] <= er[i][EXTW+FRAC-1:FRAC];
         end
         ctr3_ff <= ctr2_ff;
      end
   end

   // Stage 4: bounds and saturation into the output register.
   logic signed [BW-1:0] lo_c [3], hi_c [3];
   logic [32:0]          lo_s [3], hi_s [3];
   q16_type              min_in [3], max_in [3];
   logic                 sat_in;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         lo_c[i]   = BW'(ctr3_ff[i]) - $signed(BW'(ext3_ff[i]));
         hi_c[i]   = BW'(ctr3_ff[i]) + $signed(BW'(ext3_ff[i]));
         lo_s[i]   = sat32(lo_c[i]);
         hi_s[i]   = sat32(hi_c[i]);
         min_in[i] = lo_s[i][31:0];
         max_in[i] = hi_s[i][31:0];
         sat_in    = sat_in | lo_s[i][32] | hi_s[i][32];
      end
   end

   q16_type min_ff [3], max_ff [3];
   logic    sat_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         min_ff <= min_in;
         max_ff <= max_in;
         sat_ff <= sat_in;
      end
   end

   assign min_out = min_ff;
   assign max_out = max_ff;
   assign sat_out = sat_ff;

endmodule

`default_nettype wire

>>> rtl/oriented_rect_aabb_top.sv
// Top level of the oriented rectangle bounds block: handshake, stage
// control, configuration registers. Depends on ora_pkg and all ora_ modules.
//
// Usage. Each item on the req_ channel is one transform: position and scale
// in Q16.16 and a rotation quaternion in Q2.14. For each item the rsp_
// channel returns one item: the axis-aligned bounds of the thin oriented
// rectangle, saturated to Q16.16, with rsp_saturated set if any bound clipped.
// The csr_ channel writes the offset and half size registers by index; it is
// always ready and is meant to be written only while no item is in flight.
//
// An item passes 21 register stages: 4 front stages, 7 stages of the column
// square root (3 root digits each), 6 stages of the axis division (up to 3
// quotient bits each) and 4 back stages, the last of which is the output
// register. One item is accepted per cycle unless a stalled receiver has
// filled the pipeline.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled receiver holds only the full stages and
// bubbles keep closing up; req_ready drops once the pipeline is full.
// Reset clears the valid bits and the configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module oriented_rect_aabb_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ora_pkg::q16_type                 req_pos_x,
   input  ora_pkg::q16_type                 req_pos_y,
   input  ora_pkg::q16_type                 req_pos_z,
   input  logic signed [15:0]               req_quat_w,
   input  logic signed [15:0]               req_quat_x,
   input  logic signed [15:0]               req_quat_y,
   input  logic signed [15:0]               req_quat_z,
   input  ora_pkg::q16_type                 req_scale_x,
   input  ora_pkg::q16_type                 req_scale_y,
   input  ora_pkg::q16_type                 req_scale_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ora_pkg::q16_type                 rsp_min_x,
   output ora_pkg::q16_type                 rsp_min_y,
   output ora_pkg::q16_type                 rsp_min_z,
   output ora_pkg::q16_type                 rsp_max_x,
   output ora_pkg::q16_type                 rsp_max_y,
   output ora_pkg::q16_type                 rsp_max_z,
   output logic                             rsp_saturated,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ora_pkg::CSR_IDXW-1:0]     csr_index,
   input  logic [31:0]                      csr_wdata
);
   import ora_pkg::*;

   localparam int DLN = ST_SQRT + ST_DIV;

   // Configuration registers. Indexes outside the list are ignored.
   q16_type off_ff [3];
   q16_type half_u_ff, half_v_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         off_ff[2] <= '0;
         half_u_ff <= '0;
         half_v_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET_X: off_ff[0] <= csr_wdata;
            CSR_OFFSET_Y: off_ff[1] <= csr_wdata;
            CSR_OFFSET_Z: off_ff[2] <= csr_wdata;
            CSR_HALF_U:   half_u_ff <= csr_wdata;
            CSR_HALF_V:   half_v_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Stage control. A stage loads when it is empty or when the stage after
   // it loads in the same cycle; the last stage is the output register.
   logic [ST_TOTAL-1:0] valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[ST_TOTAL-1] = !valid_ff[ST_TOTAL-1] || rsp_ready;
      for (int k = ST_TOTAL - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign valid_in  = {valid_ff[ST_TOTAL-2:0], req_valid};
   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[ST_TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < ST_TOTAL; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Front: matrix, center, sums of squares, half extents.
   q16_type                pos_w [3], scl_w [3];
   logic signed [CTRW-1:0] f_ctr [3];
   logic [HW-1:0]          f_hu, f_hv;
   logic [SSQW-1:0]        f_ssq [3];
   logic [MAGW-1:0]        f_mag [3][3];

   assign pos_w[0] = req_pos_x;
   assign pos_w[1] = req_pos_y;
   assign pos_w[2] = req_pos_z;
   assign scl_w[0] = req_scale_x;
   assign scl_w[1] = req_scale_y;
   assign scl_w[2] = req_scale_z;

   ora_front u_front (
      .clock    (clock),
      .stage_en (stage_en[ST_FRONT-1:0]),
      .pos      (pos_w),
      .scl      (scl_w),
      .off      (off_ff),
      .half_u   (half_u_ff),
      .half_v   (half_v_ff),
      .quat_w   (req_quat_w),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .ctr      (f_ctr),
      .hu       (f_hu),
      .hv       (f_hv),
      .sumsq    (f_ssq),
      .mag      (f_mag)
   );

   // Column norms. Column 0 is the U axis, column 2 the V axis and column 1
   // the normal.
   logic [MAGW-1:0]  col_mag [3][3];
   logic [MAGW-1:0]  sq_mag  [3][3];
   logic [ROOTW-1:0] col_norm [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 3; i++) begin
            col_mag[c][i] = f_mag[i][c];
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_col
      ora_sqrt u_sqrt (
         .clock    (clock),
         .stage_en (stage_en[DV_BASE-1:SQ_BASE]),
         .ssq      (f_ssq[c]),
         .mag_in   (col_mag[c]),
         .root_out (col_norm[c]),
         .mag_out  (sq_mag[c])
      );
   end

   // Normalized axis components, one divider per matrix entry.
   logic [QW-1:0] axis_q [3][3];

   for (genvar c = 0; c < 3; c++) begin : g_dcol
      for (genvar i = 0; i < 3; i++) begin : g_drow
         ora_div u_div (
            .clock    (clock),
            .stage_en (stage_en[BK_BASE-1:DV_BASE]),
            .num_a    (sq_mag[c][i]),
            .den      (col_norm[c]),
            .quo      (axis_q[c][i])
         );
      end
   end

   // Center and half extents wait alongside the norm and division stages.
   logic signed [CTRW-1:0] dl_ctr_ff [DLN][3];
   logic [HW-1:0]          dl_hu_ff  [DLN];
   logic [HW-1:0]          dl_hv_ff  [DLN];

   for (genvar d = 0; d < DLN; d++) begin : g_delay
      if (d == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (stage_en[SQ_BASE]) begin
               dl_ctr_ff[0] <= f_ctr;
               dl_hu_ff[0]  <= f_hu;
               dl_hv_ff[0]  <= f_hv;
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (stage_en[SQ_BASE+d]) begin
               dl_ctr_ff[d] <= dl_ctr_ff[d-1];
               dl_hu_ff[d]  <= dl_hu_ff[d-1];
               dl_hv_ff[d]  <= dl_hv_ff[d-1];
            end
         end
      end
   end

   // Back: extents, bounds, saturation, output register.
   q16_type b_min [3], b_max [3];

   ora_back u_back (
      .clock    (clock),
      .stage_en (stage_en[ST_TOTAL-1:BK_BASE]),
      .ctr      (dl_ctr_ff[DLN-1]),
      .hu       (dl_hu_ff[DLN-1]),
      .hv       (dl_hv_ff[DLN-1]),
      .ua       (axis_q[0]),
      .va       (axis_q[2]),
      .na       (axis_q[1]),
      .min_out  (b_min),
      .max_out  (b_max),
      .sat_out  (rsp_saturated)
   );

   assign rsp_min_x = b_min[0];
   assign rsp_min_y = b_min[1];
   assign rsp_min_z = b_min[2];
   assign rsp_max_x = b_max[0];
   assign rsp_max_y = b_max[1];
   assign rsp_max_z = b_max[2];

   // A set saturation flag means at least one bound sits at a range limit.
   localparam q16_type Q_HI = 32'sh7FFF_FFFF;
   localparam q16_type Q_LO = 32'sh8000_0000;
   logic bound_at_limit;

   always_comb begin
      bound_at_limit = 1'b0;
      for (int i = 0; i < 3; i++) begin
         bound_at_limit = bound_at_limit || b_min[i] == Q_HI || b_min[i] == Q_LO
                        || b_max[i] == Q_HI || b_max[i] == Q_LO;
      end
   end

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled although the output register is empty");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_x <= rsp_max_x) && (rsp_min_y <= rsp_max_y)
                 && (rsp_min_z <= rsp_max_z))
      else $error("a minimum bound exceeds its maximum bound");

   a_flag_means_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> bound_at_limit)
      else $error("saturation flag set with no bound at a range limit");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result still valid after reset");

endmodule

`default_nettype wire
